// ----- src/pls_pkg.sv -----
// Shared types and constants for the positional list store.
`default_nettype none
package pls_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int POS_W         = 5;
    localparam int VAL_W         = 32;
    localparam int CNT_OUT_W     = 5;
    localparam int OP_W          = 3;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_READ   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_STEP,
        ST_SHIFT_WR,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic latch;     // capture the request
        logic decide;    // latch ok flag and start pointer
        logic rd;        // memory read
        logic wr_shift;  // write read data at pointer, move pointer
        logic place;     // write new value, count up
        logic cnt_dec;
        logic cnt_clr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic ok;
        logic more;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ----- src/pls_ctrl.sv -----
// Controller state machine for the positional list store.
`default_nettype none
module pls_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire pls_pkg::t_status  i_status,
    output pls_pkg::t_cmd          o_cmd,
    output logic                   o_busy
);
    import pls_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE:   n_state = ST_STEP;
            ST_STEP: begin
                n_state = i_status.more ? ST_SHIFT_WR : ST_FINISH;
            end
            ST_SHIFT_WR: n_state = ST_STEP;
            ST_FINISH: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy      = 1'b0;
                o_cmd.latch = i_in_valid;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            ST_STEP: begin
                // read serves both the shift and the read request
                o_cmd.rd = 1'b1;
                if (!i_status.more && i_status.ok) begin
                    case (i_status.op)
                        OP_APPEND, OP_INSERT: o_cmd.place   = 1'b1;
                        OP_POP, OP_REMOVE:    o_cmd.cnt_dec = 1'b1;
                        OP_CLEAR:             o_cmd.cnt_clr = 1'b1;
                        default:              ;
                    endcase
                end
            end
            ST_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/pls_dpath.sv -----
// Datapath for the positional list store: entry memory, count, pointer, result register.
`default_nettype none
module pls_dpath #(
    parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pls_pkg::t_cmd                 i_cmd,
    input  wire logic [pls_pkg::OP_W-1:0]      i_op,
    input  wire logic [pls_pkg::POS_W-1:0]     i_position,
    input  wire logic signed [pls_pkg::VAL_W-1:0] i_item_value,
    input  wire logic                          i_out_stall,
    output pls_pkg::t_status                   o_status,
    output logic                               o_out_valid,
    output logic                               o_ok,
    output logic signed [pls_pkg::VAL_W-1:0]   o_read_value,
    output logic [pls_pkg::CNT_OUT_W-1:0]      o_entry_count
);
    import pls_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [VAL_W-1:0]       r_mem [DEPTH];
    logic [VAL_W-1:0]       r_rd;
    t_op                    r_op;
    logic [POS_W-1:0]       r_pos;
    logic [VAL_W-1:0]       r_val;
    logic [CW-1:0]          r_count;
    logic [CMPW-1:0]        r_ptr;
    logic                   r_ok;
    logic                   r_out_valid;
    logic                   r_out_ok;
    logic [VAL_W-1:0]       r_out_value;
    logic [CNT_OUT_W-1:0]   r_out_count;

    logic [CMPW-1:0]        cntw;
    logic [CMPW-1:0]        posw;
    logic [CMPW-1:0]        epos;
    logic [CMPW-1:0]        ptr_next;
    logic                   req_ok;
    logic                   more;
    logic                   full;
    logic                   out_free;
    logic [CMPW-1:0]        rd_addr;
    logic [CMPW-1:0]        wr_addr;
    logic [VAL_W-1:0]       wr_data;

    assign cntw     = CMPW'(r_count);
    assign posw     = CMPW'(r_pos);
    assign full     = (r_count >= CW'(DEPTH));
    assign epos     = (r_op == OP_APPEND) ? cntw : posw;
    assign ptr_next = r_ptr + CMPW'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (r_op)
            OP_APPEND: req_ok = !full;
            OP_INSERT: req_ok = !full && (posw <= cntw);
            OP_POP:    req_ok = (r_count != '0);
            OP_REMOVE: req_ok = (posw < cntw);
            OP_READ:   req_ok = (posw < cntw);
            OP_CLEAR:  req_ok = 1'b1;
            default:   req_ok = 1'b0;
        endcase
    end

    always_comb begin
        case (r_op)
            OP_APPEND, OP_INSERT: more = r_ok && (r_ptr > epos);
            OP_REMOVE:            more = r_ok && (ptr_next < cntw);
            default:              more = 1'b0;
        endcase
    end

    // insert walks down from the end, remove walks up from the position
    always_comb begin
        case (r_op)
            OP_APPEND, OP_INSERT: rd_addr = r_ptr - CMPW'(1);
            OP_REMOVE:            rd_addr = ptr_next;
            default:              rd_addr = posw;
        endcase
    end

    assign wr_addr = i_cmd.place ? epos : r_ptr;
    assign wr_data = i_cmd.place ? r_val : r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift || i_cmd.place) begin
            r_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= t_op'(i_op);
            r_pos <= i_position;
            r_val <= i_item_value;
        end
        if (i_cmd.decide) begin
            r_ok  <= req_ok;
            r_ptr <= (r_op == OP_REMOVE) ? posw : cntw;
        end else if (i_cmd.wr_shift) begin
            r_ptr <= (r_op == OP_REMOVE) ? ptr_next : (r_ptr - CMPW'(1));
        end
        if (i_cmd.load_out) begin
            r_out_ok    <= r_ok;
            r_out_value <= (r_op == OP_READ && r_ok) ? r_rd : '0;
            r_out_count <= cntw[CNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.op       = r_op;
    assign o_status.ok       = r_ok;
    assign o_status.more     = more;
    assign o_status.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_read_value  = r_out_value;
    assign o_entry_count = r_out_count;

endmodule
`default_nettype wire

// ----- src/positional_list_store.sv -----
// Top level of the positional list store: controller plus datapath.
//
//   channel   direction  handshake               payload
//   request   in         i_in_valid/o_in_stall   i_op, i_position, i_item_value
//   result    out        o_out_valid/i_out_stall o_ok, o_read_value, o_entry_count
//
// A request passes the decide, step and finish states, with a shift-write and a step
// per entry shifted (insert/append move the entries at and above the position up,
// remove moves the ones above down); the single-port entry memory sets this order.
// Synchronous active-low reset clears the count, the result valid flag and the state; entries stay undefined.
// The result register holds one result; a stalled result holds the next request in
// its finish step, and requests are stalled while one is in progress.
`default_nettype none
module positional_list_store #(
    parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [pls_pkg::OP_W-1:0]          i_op,
    input  wire logic [pls_pkg::POS_W-1:0]         i_position,
    input  wire logic signed [pls_pkg::VAL_W-1:0]  i_item_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_ok,
    output logic signed [pls_pkg::VAL_W-1:0]       o_read_value,
    output logic [pls_pkg::CNT_OUT_W-1:0]          o_entry_count
);
    import pls_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    busy;

    pls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    pls_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .i_out_stall   (i_out_stall),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_ok          (o_ok),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    assign o_in_stall = busy;

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for positional_list_store: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
    import pls_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
    localparam int RANDOM_REQUESTS = 950;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef enum int { PH_FILL, PH_DRAIN, PH_MIX } t_phase_kind;

    typedef struct {
        logic                    ok;
        logic signed [VAL_W-1:0] value;
        logic [CNT_OUT_W-1:0]    count;
    } t_list_result;

    class list_scoreboard;
        logic signed [VAL_W-1:0] slots [LIST_DEPTH];
        int held;
        int errors;
        t_list_result expected_q[$];

        function new();
            held = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit place_value(int pos, logic signed [VAL_W-1:0] val);
            if (held >= LIST_DEPTH || pos > held) return 1'b0;
            for (int k = held; k > pos; k--) slots[k] = slots[k-1];
            slots[pos] = val;
            held++;
            return 1'b1;
        endfunction

        function bit take_value(int pos);
            if (pos >= held) return 1'b0;
            for (int k = pos; k + 1 < held; k++) slots[k] = slots[k+1];
            held--;
            return 1'b1;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] val);
            t_list_result res;
            res.ok = 1'b0;
            res.value = '0;
            case (op)
                OP_APPEND: res.ok = place_value(held, val);
                OP_INSERT: res.ok = place_value(int'(pos), val);
                OP_POP:    res.ok = (held > 0) ? take_value(held - 1) : 1'b0;
                OP_REMOVE: res.ok = take_value(int'(pos));
                OP_READ: begin
                    if (int'(pos) < held) begin
                        res.value = slots[pos];
                        res.ok = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    held = 0;
                    res.ok = 1'b1;
                end
                default: ;
            endcase
            res.count = CNT_OUT_W'(held);
            expected_q.push_back(res);
        endfunction

        function void check_result(logic ok, logic signed [VAL_W-1:0] value,
                                   logic [CNT_OUT_W-1:0] count);
            t_list_result exp_res;
            if (expected_q.size() == 0) begin
                $error("result with no request pending: ok=%0b read_value=%0d entry_count=%0d",
                       ok, value, count);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (ok !== exp_res.ok) begin
                $error("ok: expected %0b, got %0b", exp_res.ok, ok);
                errors++;
            end
            if (value !== exp_res.value) begin
                $error("read_value: expected %0d, got %0d", exp_res.value, value);
                errors++;
            end
            if (count !== exp_res.count) begin
                $error("entry_count: expected %0d, got %0d", exp_res.count, count);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [OP_W-1:0]         i_op;
    logic [POS_W-1:0]        i_position;
    logic signed [VAL_W-1:0] i_item_value;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_ok;
    logic signed [VAL_W-1:0] o_read_value;
    logic [CNT_OUT_W-1:0]    o_entry_count;

    list_scoreboard sb = new();
    int sender_max_gap = 10;
    int receiver_max_gap = 10;
    int idle_cycles = 0;

    positional_list_store #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: stall a random number of cycles before taking each result.
    initial begin
        int gap;
        i_out_stall <= 1'b1;
        // hold off until reset has settled the result register
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, receiver_max_gap);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_result(o_ok, o_read_value, o_entry_count);
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val);
        int gap;
        gap = $urandom_range(0, sender_max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_position <= pos;
        i_item_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(op, pos, val);
    endtask

    // Hold off new requests until the block has answered everything.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(t_phase_kind kind);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 97) return (r == 99) ? OP_SPARE_7 : OP_SPARE_6;
        case (kind)
            PH_FILL: begin
                if (r < 45) return OP_APPEND;
                if (r < 80) return OP_INSERT;
                if (r < 90) return OP_READ;
                if (r < 94) return OP_REMOVE;
                return OP_POP;
            end
            PH_DRAIN: begin
                if (r < 35) return OP_REMOVE;
                if (r < 65) return OP_POP;
                if (r < 80) return OP_READ;
                if (r < 88) return OP_INSERT;
                if (r < 95) return OP_APPEND;
                return OP_CLEAR;
            end
            default: begin
                if (r < 20) return OP_APPEND;
                if (r < 40) return OP_INSERT;
                if (r < 55) return OP_POP;
                if (r < 70) return OP_REMOVE;
                if (r < 95) return OP_READ;
                return OP_CLEAR;
            end
        endcase
    endfunction

    // Mostly legal positions, now and then anything the field can carry.
    function automatic logic [POS_W-1:0] pick_position(logic [OP_W-1:0] op);
        if ($urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 31));
        if (op == OP_INSERT) return POS_W'($urandom_range(0, sb.held));
        if (sb.held == 0) return '0;
        return POS_W'($urandom_range(0, sb.held - 1));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_idling();
        sender_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
        receiver_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
    endtask

    initial begin
        logic [OP_W-1:0] op;
        t_phase_kind kind;
        int sent;
        int len;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_op <= OP_APPEND;
        i_position <= '0;
        i_item_value <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store: everything but clear, append and insert at position 0 fails.
        send_request(OP_CLEAR, 5'd0, 32'sd0);
        send_request(OP_POP, 5'd0, 32'sd0);
        send_request(OP_REMOVE, 5'd0, 32'sd0);
        send_request(OP_READ, 5'd0, 32'sd0);
        send_request(OP_INSERT, 5'd1, 32'sd7);
        send_request(OP_APPEND, 5'd31, 32'sh7fffffff);
        send_request(OP_APPEND, 5'd0, 32'sh80000000);
        send_request(OP_INSERT, 5'd0, -32'sd1);
        send_request(OP_INSERT, 5'd3, 32'sd0);
        send_request(OP_INSERT, 5'd2, 32'sh55555555);
        send_request(OP_INSERT, 5'd6, 32'sd9);
        send_request(OP_READ, 5'd0, 32'sd0);
        send_request(OP_READ, 5'd2, 32'sd0);
        send_request(OP_READ, 5'd4, 32'sd0);
        send_request(OP_READ, 5'd31, 32'sd0);
        send_request(OP_REMOVE, 5'd1, 32'sd0);
        send_request(OP_REMOVE, 5'd31, 32'sd0);
        send_request(OP_REMOVE, 5'd4, 32'sd0);
        send_request(OP_SPARE_6, 5'd1, 32'sd3);
        send_request(OP_SPARE_7, 5'd2, 32'sd4);
        send_request(OP_POP, 5'd0, 32'sd0);
        send_request(OP_READ, 5'd2, 32'sd0);
        send_request(OP_CLEAR, 5'd0, 32'sd0);
        send_request(OP_READ, 5'd0, 32'sd0);
        wait_for_results();

        // Fill to the top, then knock on a full store.
        sent = 0;
        pick_idling();
        while (sb.held < LIST_DEPTH) begin
            op = ($urandom_range(0, 1) == 0) ? OP_APPEND : OP_INSERT;
            send_request(op, pick_position(op), pick_value());
            sent++;
        end
        send_request(OP_APPEND, 5'd0, pick_value());
        send_request(OP_INSERT, 5'd0, pick_value());
        send_request(OP_INSERT, 5'(LIST_DEPTH), pick_value());
        send_request(OP_READ, 5'(LIST_DEPTH - 1), 32'sd0);
        send_request(OP_READ, 5'(LIST_DEPTH), 32'sd0);
        sent += 5;

        while (sent < RANDOM_REQUESTS) begin
            kind = t_phase_kind'($urandom_range(0, 2));
            len = $urandom_range(15, 50);
            pick_idling();
            for (int i = 0; i < len; i++) begin
                op = pick_op(kind);
                send_request(op, pick_position(op), pick_value());
                sent++;
            end
            if ($urandom_range(0, 3) == 0) wait_for_results();
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/pls_pkg.sv
src/pls_ctrl.sv
src/pls_dpath.sv
src/positional_list_store.sv
test/tb_top.sv
